[rtl/core/rsp_pkg.sv]
// Shared types, constants and helper functions for the row shelf placement unit.
// Used by rsp_isqrt, rsp_divider and row_shelf_placement_unit; no dependencies.
package rsp_pkg;

    localparam int MAX_ELEMENTS = 64;
    localparam int DIM_BITS     = 10;
    localparam int IDX_W        = 6;
    localparam int CNT_W        = 7;
    localparam int AREA_W       = 27;
    localparam int SUM_W        = 16;
    localparam int POS_W        = 18;
    localparam int ROOT_W       = 14;
    localparam int COEFF_W      = 11;
    localparam int PROD_W       = 26;

    localparam logic [COEFF_W-1:0] COEFF_MIN   = 11'd256;
    localparam logic [COEFF_W-1:0] COEFF_MAX   = 11'd1024;
    localparam logic [PROD_W-1:0]  ROUND_HALF  = 26'd128;
    localparam logic [3:0]         SQRT_LAST   = 4'd13;
    localparam logic [4:0]         DIV_LAST    = 5'd17;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQRT_GO,
        S_SQRT_WAIT,
        S_PW_MUL,
        S_PW_CMP,
        S_PACK_RD,
        S_PACK,
        S_PACK_END,
        S_SP_MUL,
        S_SP_SUB,
        S_SP_DIV,
        S_SP_WAIT,
        S_ROW_RD,
        S_ROW_LOAD,
        S_EL_RD,
        S_EL_OUT
    } rsp_state_t;

    typedef struct packed {
        logic [SUM_W-1:0] width_sum;
        logic [CNT_W-1:0] members;
        logic [SUM_W-1:0] y_base;
    } row_entry_t;

    // Gap k of a span: quotient plus one for the first r gaps, and the first
    // gap halved with its odd unit kept.
    function automatic logic [POS_W-1:0] gap_f(input logic [POS_W-1:0] q,
                                               input logic [CNT_W-1:0] k,
                                               input logic [CNT_W-1:0] r);
        logic [POS_W-1:0] g;
        begin
            g = q + ((k < r) ? {{(POS_W-1){1'b0}}, 1'b1} : '0);
            if (k == '0)
            begin
                g = {1'b0, g[POS_W-1:1]} + {{(POS_W-1){1'b0}}, g[0]};
            end
            return g;
        end
    endfunction

endpackage

[rtl/core/rsp_isqrt.sv]
// Bit-pair integer square root, two radicand bits per cycle.
// Depends on rsp_pkg.
module rsp_isqrt
    import rsp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [AREA_W-1:0] radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;

    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, rad_reg[2*ROOT_W-1:2*ROOT_W-2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        if (start)
        begin
            rad_next  = {1'b0, radicand};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[2*ROOT_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = diff[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == SQRT_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/core/rsp_divider.sv]
// Restoring divider, one quotient bit per cycle, for splitting expansion space.
// Depends on rsp_pkg.
module rsp_divider
    import rsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic             done,
    output logic [POS_W-1:0] quotient,
    output logic [CNT_W-1:0] remainder
);

    logic [POS_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] dvs_reg, dvs_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [CNT_W:0]   rem_sh;
    logic [CNT_W:0]   diff;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[POS_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[POS_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[CNT_W-1:0];
                quo_next = {quo_reg[POS_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == DIV_LAST)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[rtl/core/row_shelf_placement_unit.sv]
// Row shelf placement unit: loads rectangles, packs them next-fit into rows
// and emits expanded top-left coordinates. Depends on rsp_pkg, rsp_isqrt and rsp_divider.
//
// Usage: present an item (element_width, element_height, is_last) with start
// high; it is taken at a rising edge where busy is low. A non-last item is
// stored (busy stays low), up to 64 items; more are dropped.
// An item with is_last set raises busy and starts placement:
//   square root of the total area, with setup before it and rounding after,
//   packing: one element store read per element,
//   spreading: a division for the row split and one more per row,
//   emission: one result strobe per element.
// Results appear on pos_x, pos_y, row_number, element_number and final_result
// for exactly one cycle while result_valid is high; the receiver cannot stall.
// busy drops in the cycle that carries the final result, and the next set may
// be loaded at once. Write the Q3.8 coefficient through cfg_wr_en/cfg_wr_data
// while busy is low. Reset clears the element count and area and sets the
// coefficient to 1.0; the stores themselves are not cleared.
module row_shelf_placement_unit
    import rsp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [DIM_BITS-1:0] element_width,
    input  logic [DIM_BITS-1:0] element_height,
    input  logic                is_last,
    input  logic                cfg_wr_en,
    input  logic [COEFF_W-1:0]  cfg_wr_data,
    output logic                result_valid,
    output logic [POS_W-1:0]    pos_x,
    output logic [POS_W-1:0]    pos_y,
    output logic [IDX_W-1:0]    row_number,
    output logic [IDX_W-1:0]    element_number,
    output logic                final_result
);

    rsp_state_t state_reg, state_next;

    logic [COEFF_W-1:0] coeff_reg;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [AREA_W-1:0]  area_reg, area_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [ROOT_W-1:0]  pw_reg, pw_next;
    logic [2*ROOT_W:0]  pwp_reg, pwp_next;

    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [SUM_W-1:0]   cur_x_reg, cur_x_next;
    logic [SUM_W-1:0]   row_y_reg, row_y_next;
    logic [DIM_BITS-1:0] first_h_reg, first_h_next;
    logic [SUM_W-1:0]   rws_reg, rws_next;
    logic [CNT_W-1:0]   rmc_reg, rmc_next;
    logic [SUM_W-1:0]   rhs_reg, rhs_next;

    logic [SUM_W-1:0]   total_reg, total_next;
    logic [CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic               sp_rows_reg, sp_rows_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [POS_W-1:0]   diff_reg, diff_next;
    logic [POS_W-1:0]   rq_reg, rq_next;
    logic [CNT_W-1:0]   rr_reg, rr_next;
    logic [POS_W-1:0]   cq_reg, cq_next;
    logic [CNT_W-1:0]   cr_reg, cr_next;
    logic [POS_W-1:0]   row_cum_reg, row_cum_next;
    logic [POS_W-1:0]   col_cum_reg, col_cum_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [SUM_W-1:0]   ry_reg, ry_next;

    logic               rv_reg, rv_next;
    logic [POS_W-1:0]   px_reg, px_next;
    logic [POS_W-1:0]   py_reg, py_next;
    logic [IDX_W-1:0]   rn_reg, rn_next;
    logic [IDX_W-1:0]   en_reg, en_next;
    logic               fin_reg, fin_next;

    // Element sizes, packed x offsets and per-row records.
    logic [2*DIM_BITS-1:0] wh_mem [MAX_ELEMENTS];
    logic [SUM_W-1:0]      x_mem  [MAX_ELEMENTS];
    row_entry_t            row_mem[MAX_ELEMENTS];

    logic                  wh_we, x_we, row_we;
    logic [IDX_W-1:0]      wh_waddr, wh_raddr, x_waddr, x_raddr, row_waddr, row_raddr;
    logic [2*DIM_BITS-1:0] wh_wdata, wh_q;
    logic [SUM_W-1:0]      x_wdata, x_q;
    row_entry_t            row_wdata, row_q;

    logic                  sq_start, sq_done;
    logic [ROOT_W-1:0]     sq_root;
    logic                  dv_start, dv_done;
    logic [POS_W-1:0]      dv_quo;
    logic [CNT_W-1:0]      dv_rem;

    logic                  accept;
    logic [COEFF_W-1:0]    coeff_use;
    logic [DIM_BITS-1:0]   cur_w, cur_h;
    logic [SUM_W:0]        fit_sum;
    logic                  new_row;
    logic [POS_W-1:0]      cc;
    logic                  last_el;
    logic [CNT_W-1:0]      k_inc;

    rsp_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (area_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    rsp_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (dv_start),
        .dividend  (diff_reg),
        .divisor   (div_cnt_reg),
        .done      (dv_done),
        .quotient  (dv_quo),
        .remainder (dv_rem)
    );

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        if (coeff_reg < COEFF_MIN)
        begin
            coeff_use = COEFF_MIN;
        end
        else if (coeff_reg > COEFF_MAX)
        begin
            coeff_use = COEFF_MAX;
        end
        else
        begin
            coeff_use = coeff_reg;
        end
    end

    assign cur_w   = wh_q[2*DIM_BITS-1:DIM_BITS];
    assign cur_h   = wh_q[DIM_BITS-1:0];
    assign fit_sum = {1'b0, cur_x_reg} + {{(SUM_W+1-DIM_BITS){1'b0}}, cur_w};
    assign new_row = (idx_reg == '0) ||
                     (fit_sum > {{(SUM_W+1-ROOT_W){1'b0}}, pw_reg});
    assign cc      = col_cum_reg + gap_f(cq_reg, k_reg, cr_reg);
    assign last_el = ({1'b0, idx_reg} + 7'd1) == n_reg;
    assign k_inc   = k_reg + 7'd1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        area_next    = area_reg;
        n_next       = n_reg;
        pw_next      = pw_reg;
        pwp_next     = pwp_reg;
        idx_next     = idx_reg;
        row_next     = row_reg;
        cur_x_next   = cur_x_reg;
        row_y_next   = row_y_reg;
        first_h_next = first_h_reg;
        rws_next     = rws_reg;
        rmc_next     = rmc_reg;
        rhs_next     = rhs_reg;
        total_next   = total_reg;
        div_cnt_next = div_cnt_reg;
        sp_rows_next = sp_rows_reg;
        prod_next    = prod_reg;
        diff_next    = diff_reg;
        rq_next      = rq_reg;
        rr_next      = rr_reg;
        cq_next      = cq_reg;
        cr_next      = cr_reg;
        row_cum_next = row_cum_reg;
        col_cum_next = col_cum_reg;
        k_next       = k_reg;
        ry_next      = ry_reg;
        rv_next      = 1'b0;
        px_next      = px_reg;
        py_next      = py_reg;
        rn_next      = rn_reg;
        en_next      = en_reg;
        fin_next     = fin_reg;

        wh_we     = 1'b0;
        wh_waddr  = count_reg[IDX_W-1:0];
        wh_wdata  = {element_width, element_height};
        wh_raddr  = idx_reg;
        x_we      = 1'b0;
        x_waddr   = idx_reg;
        x_wdata   = cur_x_reg;
        x_raddr   = idx_reg;
        row_we    = 1'b0;
        row_waddr = row_reg;
        row_wdata = '{width_sum: rws_reg, members: rmc_reg, y_base: row_y_reg};
        row_raddr = row_reg;
        sq_start  = 1'b0;
        dv_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        wh_we      = 1'b1;
                        area_next  = area_reg + AREA_W'(element_width * element_height);
                        count_next = count_reg + 7'd1;
                    end
                    if (is_last)
                    begin
                        n_next     = count_next;
                        state_next = S_SQRT_GO;
                    end
                end
            end
            S_SQRT_GO:
            begin
                sq_start   = 1'b1;
                state_next = S_SQRT_WAIT;
            end
            S_SQRT_WAIT:
            begin
                if (sq_done)
                begin
                    pw_next    = sq_root;
                    state_next = S_PW_MUL;
                end
            end
            S_PW_MUL:
            begin
                pwp_next   = (2*ROOT_W+1)'(pw_reg * ({1'b0, pw_reg} + 15'd1));
                state_next = S_PW_CMP;
            end
            S_PW_CMP:
            begin
                if (pwp_reg < {2'b00, area_reg})
                begin
                    pw_next = pw_reg + 14'd1;
                end
                idx_next   = '0;
                row_next   = '0;
                state_next = S_PACK_RD;
            end
            S_PACK_RD:
            begin
                state_next = S_PACK;
            end
            S_PACK:
            begin
                x_we = 1'b1;
                if (new_row)
                begin
                    x_wdata = '0;
                    if (idx_reg != '0)
                    begin
                        row_we     = 1'b1;
                        row_next   = row_reg + 6'd1;
                        row_y_next = row_y_reg + SUM_W'(first_h_reg);
                        rhs_next   = rhs_reg + SUM_W'(cur_h);
                    end
                    else
                    begin
                        row_y_next = '0;
                        rhs_next   = SUM_W'(cur_h);
                    end
                    rws_next     = SUM_W'(cur_w);
                    rmc_next     = 7'd1;
                    cur_x_next   = SUM_W'(cur_w);
                    first_h_next = cur_h;
                end
                else
                begin
                    rws_next   = rws_reg + SUM_W'(cur_w);
                    rmc_next   = rmc_reg + 7'd1;
                    cur_x_next = fit_sum[SUM_W-1:0];
                end
                if (last_el)
                begin
                    state_next = S_PACK_END;
                end
                else
                begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = S_PACK_RD;
                end
            end
            S_PACK_END:
            begin
                row_we       = 1'b1;
                total_next   = rhs_reg;
                div_cnt_next = {1'b0, row_reg} + 7'd1;
                sp_rows_next = 1'b1;
                state_next   = S_SP_MUL;
            end
            S_SP_MUL:
            begin
                prod_next  = PROD_W'(total_reg * coeff_use) + ROUND_HALF;
                state_next = S_SP_SUB;
            end
            S_SP_SUB:
            begin
                diff_next  = prod_reg[PROD_W-1:8] - POS_W'(total_reg);
                state_next = S_SP_DIV;
            end
            S_SP_DIV:
            begin
                dv_start   = 1'b1;
                state_next = S_SP_WAIT;
            end
            S_SP_WAIT:
            begin
                if (dv_done)
                begin
                    if (sp_rows_reg)
                    begin
                        rq_next      = dv_quo;
                        rr_next      = dv_rem;
                        row_next     = '0;
                        idx_next     = '0;
                        row_cum_next = '0;
                        state_next   = S_ROW_RD;
                    end
                    else
                    begin
                        cq_next      = dv_quo;
                        cr_next      = dv_rem;
                        k_next       = '0;
                        col_cum_next = '0;
                        state_next   = S_EL_RD;
                    end
                end
            end
            S_ROW_RD:
            begin
                state_next = S_ROW_LOAD;
            end
            S_ROW_LOAD:
            begin
                ry_next      = row_q.y_base;
                rmc_next     = row_q.members;
                total_next   = row_q.width_sum;
                div_cnt_next = row_q.members;
                row_cum_next = row_cum_reg + gap_f(rq_reg, {1'b0, row_reg}, rr_reg);
                sp_rows_next = 1'b0;
                state_next   = S_SP_MUL;
            end
            S_EL_RD:
            begin
                state_next = S_EL_OUT;
            end
            S_EL_OUT:
            begin
                rv_next      = 1'b1;
                px_next      = POS_W'(x_q) + cc;
                py_next      = POS_W'(ry_reg) + row_cum_reg;
                rn_next      = row_reg;
                en_next      = idx_reg;
                fin_next     = last_el;
                col_cum_next = cc;
                k_next       = k_inc;
                if (last_el)
                begin
                    count_next = '0;
                    area_next  = '0;
                    state_next = S_IDLE;
                end
                else if (k_inc == rmc_reg)
                begin
                    idx_next   = idx_reg + 6'd1;
                    row_next   = row_reg + 6'd1;
                    state_next = S_ROW_RD;
                end
                else
                begin
                    idx_next   = idx_reg + 6'd1;
                    state_next = S_EL_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            coeff_reg <= COEFF_MIN;
            count_reg <= '0;
            area_reg  <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                coeff_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            area_reg  <= area_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        pw_reg      <= pw_next;
        pwp_reg     <= pwp_next;
        idx_reg     <= idx_next;
        row_reg     <= row_next;
        cur_x_reg   <= cur_x_next;
        row_y_reg   <= row_y_next;
        first_h_reg <= first_h_next;
        rws_reg     <= rws_next;
        rmc_reg     <= rmc_next;
        rhs_reg     <= rhs_next;
        total_reg   <= total_next;
        div_cnt_reg <= div_cnt_next;
        sp_rows_reg <= sp_rows_next;
        prod_reg    <= prod_next;
        diff_reg    <= diff_next;
        rq_reg      <= rq_next;
        rr_reg      <= rr_next;
        cq_reg      <= cq_next;
        cr_reg      <= cr_next;
        row_cum_reg <= row_cum_next;
        col_cum_reg <= col_cum_next;
        k_reg       <= k_next;
        ry_reg      <= ry_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        rn_reg      <= rn_next;
        en_reg      <= en_next;
        fin_reg     <= fin_next;
    end

    always_ff @(posedge clk)
    begin
        if (wh_we)
        begin
            wh_mem[wh_waddr] <= wh_wdata;
        end
        wh_q <= wh_mem[wh_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
        begin
            x_mem[x_waddr] <= x_wdata;
        end
        x_q <= x_mem[x_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_q <= row_mem[row_raddr];
    end

    assign result_valid   = rv_reg;
    assign pos_x          = px_reg;
    assign pos_y          = py_reg;
    assign row_number     = rn_reg;
    assign element_number = en_reg;
    assign final_result   = fin_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count exceeds store depth");

    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_result) |-> !busy)
        else $error("final result shown while still busy");

    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && final_result))
        else $error("placement ended without a final result");

    a_sqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sq_done |-> (state_reg == S_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dv_done |-> (state_reg == S_SP_WAIT))
        else $error("divider finished outside its wait state");
`endif

endmodule

[bench/tb_top.sv]
// Self-checking bench for row_shelf_placement_unit: loads rectangle sets,
// predicts every expanded placement and compares each result strobe.
// Depends on rsp_pkg and the placement unit RTL.
`timescale 1ns / 100ps

module tb_top;
    import rsp_pkg::*;

    typedef struct {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic             fin;
    } placement_t;

    class placement_board;
        logic [COEFF_W-1:0] coeff;
        longint             widths[MAX_ELEMENTS];
        longint             heights[MAX_ELEMENTS];
        int                 count;
        longint             area;
        placement_t         pending[$];
        int                 errors;

        function new();
            coeff = COEFF_MIN;
            count = 0;
            area = 0;
            errors = 0;
        endfunction

        function longint root_floor(longint v);
            longint res;
            longint bitv;
            res = 0;
            bitv = 64'sd1 << 62;
            while (bitv > v) bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return root_floor_done(res);
        endfunction

        function longint root_floor_done(longint r);
            return r;
        endfunction

        // Running sum of the expansion gaps for a span shared by n items.
        function void gap_sums(longint span, int n, ref longint cum[MAX_ELEMENTS]);
            longint c;
            longint diff;
            longint q;
            longint r;
            longint s;
            longint g;
            c = coeff;
            if (c < 256) c = 256;
            if (c > 1024) c = 1024;
            if (n == 0) return;
            diff = ((span * c + 128) >> 8) - span;
            q = diff / n;
            r = diff % n;
            s = 0;
            for (int k = 0; k < n; k++)
            begin
                g = q + ((k < r) ? 1 : 0);
                if (k == 0) g = g / 2 + (g & 1);
                s = s + g;
                cum[k] = s;
            end
        endfunction

        function void note_item(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h,
                                logic last);
            longint pw;
            longint cur_x;
            longint cur_y;
            longint first_h;
            longint xs[MAX_ELEMENTS];
            longint ys[MAX_ELEMENTS];
            int     row_of[MAX_ELEMENTS];
            longint row_w[MAX_ELEMENTS];
            int     members[MAX_ELEMENTS];
            longint row_cum[MAX_ELEMENTS];
            longint col_cum[MAX_ELEMENTS];
            longint height_sum;
            int     rows;
            int     r;
            int     first;
            placement_t p;
            if (count < MAX_ELEMENTS)
            begin
                widths[count] = w;
                heights[count] = h;
                area = (area + longint'(w) * longint'(h)) & ((64'sd1 << AREA_W) - 1);
                count++;
            end
            if (!last) return;
            pw = root_floor(area);
            if (pw * (pw + 1) < area) pw++;
            cur_x = 0;
            cur_y = 0;
            first_h = 0;
            rows = 0;
            r = 0;
            height_sum = 0;
            for (int i = 0; i < count; i++)
            begin
                if (i == 0 || cur_x + widths[i] > pw)
                begin
                    if (i != 0) cur_y += first_h;
                    r = rows++;
                    row_w[r] = widths[i] & 16'hFFFF;
                    members[r] = 1;
                    xs[i] = 0;
                    cur_x = widths[i];
                    first_h = heights[i];
                    height_sum = (height_sum + heights[i]) & 16'hFFFF;
                end
                else
                begin
                    xs[i] = cur_x;
                    row_w[r] = (row_w[r] + widths[i]) & 16'hFFFF;
                    members[r]++;
                    cur_x += widths[i];
                end
                ys[i] = cur_y;
                row_of[i] = r;
            end
            gap_sums(height_sum, rows, row_cum);
            first = 0;
            for (int rr = 0; rr < rows; rr++)
            begin
                gap_sums(row_w[rr], members[rr], col_cum);
                for (int k = 0; k < members[rr] && first + k < count; k++)
                begin
                    xs[first + k] = (xs[first + k] + col_cum[k]) & 18'h3FFFF;
                    ys[first + k] = (ys[first + k] + row_cum[rr]) & 18'h3FFFF;
                end
                first += members[rr];
            end
            for (int i = 0; i < count; i++)
            begin
                p.x = xs[i][POS_W-1:0];
                p.y = ys[i][POS_W-1:0];
                p.row = row_of[i][IDX_W-1:0];
                p.idx = i[IDX_W-1:0];
                p.fin = (i + 1 == count);
                pending.push_back(p);
            end
            count = 0;
            area = 0;
        endfunction

        function void check_result(placement_t got);
            placement_t exp_p;
            if (pending.size() == 0)
            begin
                $error("unexpected result: element_number %0d", got.idx);
                errors++;
                return;
            end
            exp_p = pending.pop_front();
            if (got.x !== exp_p.x)
            begin
                $error("pos_x: expected %0d, got %0d", exp_p.x, got.x);
                errors++;
            end
            if (got.y !== exp_p.y)
            begin
                $error("pos_y: expected %0d, got %0d", exp_p.y, got.y);
                errors++;
            end
            if (got.row !== exp_p.row)
            begin
                $error("row_number: expected %0d, got %0d", exp_p.row, got.row);
                errors++;
            end
            if (got.idx !== exp_p.idx)
            begin
                $error("element_number: expected %0d, got %0d", exp_p.idx, got.idx);
                errors++;
            end
            if (got.fin !== exp_p.fin)
            begin
                $error("final_result: expected %0d, got %0d", exp_p.fin, got.fin);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [DIM_BITS-1:0] element_width;
    logic [DIM_BITS-1:0] element_height;
    logic                is_last;
    logic                cfg_wr_en;
    logic [COEFF_W-1:0]  cfg_wr_data;
    logic                result_valid;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [IDX_W-1:0]    row_number;
    logic [IDX_W-1:0]    element_number;
    logic                final_result;

    placement_board board = new();
    int             sent = 0;
    bit             quiet = 0;

    row_shelf_placement_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .element_width(element_width),
        .element_height(element_height),
        .is_last(is_last),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .result_valid(result_valid),
        .pos_x(pos_x),
        .pos_y(pos_y),
        .row_number(row_number),
        .element_number(element_number),
        .final_result(final_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        placement_t got;
        if (rst_n && result_valid)
        begin
            got.x = pos_x;
            got.y = pos_y;
            got.row = row_number;
            got.idx = element_number;
            got.fin = final_result;
            board.check_result(got);
        end
    end

    task automatic send_item(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h,
                             input logic last);
        if (!quiet && $urandom_range(99) < 14)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        element_width <= w;
        element_height <= h;
        is_last <= last;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_item(w, h, last);
        sent++;
    endtask

    // Hold the sender until every placement has come back, then let the
    // block settle before touching the coefficient.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_coeff(input logic [COEFF_W-1:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        board.coeff = v;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_set();
        int n;
        int pick;
        int narrow;
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] h;
        pick = $urandom_range(99);
        if (pick < 85) n = $urandom_range(1, 10);
        else if (pick < 96) n = $urandom_range(11, 30);
        else if (pick < 98) n = MAX_ELEMENTS;
        else n = MAX_ELEMENTS + 3;
        narrow = $urandom_range(1);
        for (int i = 0; i < n; i++)
        begin
            if (narrow) w = DIM_BITS'($urandom_range(1, 40));
            else w = DIM_BITS'($urandom);
            h = DIM_BITS'($urandom);
            if ($urandom_range(49) == 0) w = '0;
            if ($urandom_range(49) == 0) h = '0;
            send_item(w, h, i == n - 1);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        element_width = '0;
        element_height = '0;
        is_last = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets at the edges of sizes and coefficient.
        send_item(10'd1023, 10'd1023, 1'b1);
        send_item(10'd0, 10'd0, 1'b0);
        send_item(10'd0, 10'd5, 1'b0);
        send_item(10'd7, 10'd0, 1'b1);
        write_coeff(COEFF_MAX);
        send_item(10'd1, 10'd1, 1'b0);
        send_item(10'd1023, 10'd1, 1'b0);
        send_item(10'd1, 10'd1023, 1'b0);
        send_item(10'd512, 10'd512, 1'b0);
        send_item(10'd3, 10'd3, 1'b1);
        write_coeff(11'd0);
        send_item(10'd20, 10'd9, 1'b0);
        send_item(10'd5, 10'd4, 1'b1);
        write_coeff(11'd2047);
        send_item(10'd682, 10'd341, 1'b0);
        send_item(10'd4, 10'd2, 1'b0);
        send_item(10'd4, 10'd2, 1'b1);
        write_coeff(COEFF_MIN + 11'd1);
        send_item(10'd2, 10'd6, 1'b0);
        send_item(10'd2, 10'd6, 1'b0);
        send_item(10'd9, 10'd1, 1'b1);

        while (sent < 310)
        begin
            quiet = (sent >= 120 && sent < 190);
            if ($urandom_range(3) == 0) write_coeff(COEFF_W'($urandom_range(256, 1024)));
            random_set();
        end
        drain();
        repeat (20) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/rsp_pkg.sv
rtl/core/rsp_isqrt.sv
rtl/core/rsp_divider.sv
rtl/core/row_shelf_placement_unit.sv
bench/tb_top.sv
